### rtl/ads_pkg.sv
// Shared constants and control types for the area downsample scaler.
`default_nettype none
package ads_pkg;
	localparam int MaxWidth   = 4096;
	localparam int MaxHeight  = 4096;
	localparam int Lanes      = 4;
	localparam int DimW       = 13;
	localparam int AddrW      = 12;
	localparam int PosW       = 25;
	localparam int PartW      = 24;
	localparam int SumW       = 36;
	localparam int QuoW       = 9;
	localparam int DivSteps   = 9;

	localparam logic [2:0] RegSrcWidth  = 3'd0;
	localparam logic [2:0] RegSrcHeight = 3'd1;
	localparam logic [2:0] RegDstWidth  = 3'd2;
	localparam logic [2:0] RegDstHeight = 3'd3;
	localparam logic [2:0] RegFourChan  = 3'd4;

	typedef struct packed {
		logic clr;
		logic load;
		logic mul1;
		logic mul2;
		logic wb;
		logic div;
		logic emit;
		logic adv;
	} ads_cmd_t;

	typedef struct packed {
		logic cfg_hit;
		logic clr_last;
		logic take;
		logic col_done;
		logic row_done;
		logic div_last;
		logic out_full;
	} ads_sts_t;
endpackage
`default_nettype wire

### rtl/ads_if.sv
// Stream interfaces for source pixels and destination pixels.
`default_nettype none
interface ads_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] chan_a_in;
	logic [7:0] chan_b_in;
	logic [7:0] chan_c_in;
	logic [7:0] chan_d_in;
	modport source (output valid, chan_a_in, chan_b_in, chan_c_in, chan_d_in, input ready);
	modport sink (input valid, chan_a_in, chan_b_in, chan_c_in, chan_d_in, output ready);
endinterface

interface ads_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] chan_a_out;
	logic [7:0] chan_b_out;
	logic [7:0] chan_c_out;
	logic [7:0] chan_d_out;
	logic       row_end;
	logic       frame_end;
	modport source (output valid, chan_a_out, chan_b_out, chan_c_out, chan_d_out, row_end,
		frame_end, input ready);
	modport sink (input valid, chan_a_out, chan_b_out, chan_c_out, chan_d_out, row_end,
		frame_end, output ready);
endinterface
`default_nettype wire

### rtl/ads_ctrl.sv
// Sequencer for the area downsample scaler.
`default_nettype none
module ads_ctrl
	import ads_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire ads_sts_t sts,
	output ads_cmd_t      cmd,
	output logic          idle
);
	localparam logic [2:0] StClr  = 3'd0;
	localparam logic [2:0] StIdle = 3'd1;
	localparam logic [2:0] StLd   = 3'd2;
	localparam logic [2:0] StMul1 = 3'd3;
	localparam logic [2:0] StMul2 = 3'd4;
	localparam logic [2:0] StWb   = 3'd5;
	localparam logic [2:0] StDiv  = 3'd6;
	localparam logic [2:0] StOut  = 3'd7;

	logic [2:0] state_q, state_d;
	logic       adv_q, adv_d;

	always_comb begin
		state_d = state_q;
		adv_d   = 1'b0;
		cmd     = '0;
		idle    = 1'b0;
		case (state_q)
			StClr: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) state_d = StIdle;
			end
			StIdle: begin
				idle = ~adv_q;
				cmd.adv = adv_q;
				if (!adv_q) begin
					cmd.load = 1'b1;
					if (sts.take) state_d = StLd;
				end
			end
			StLd: state_d = StMul1;
			StMul1: begin
				cmd.mul1 = 1'b1;
				if (sts.col_done) state_d = StMul2;
				else begin
					state_d = StIdle;
					adv_d   = 1'b1;
				end
			end
			StMul2: begin
				cmd.mul2 = 1'b1;
				state_d  = StWb;
			end
			StWb: begin
				cmd.wb = 1'b1;
				if (sts.row_done) state_d = StDiv;
				else begin
					state_d = StIdle;
					adv_d   = 1'b1;
				end
			end
			StDiv: begin
				cmd.div = 1'b1;
				if (sts.div_last) state_d = StOut;
			end
			StOut: begin
				if (!sts.out_full) begin
					cmd.emit = 1'b1;
					state_d  = StIdle;
					adv_d    = 1'b1;
				end
			end
			default: state_d = StClr;
		endcase
		if (sts.cfg_hit) begin
			state_d = StClr;
			adv_d   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StClr;
			adv_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			adv_q   <= adv_d;
		end
	end
endmodule
`default_nettype wire

### rtl/ads_dp.sv
// Datapath: counters, weights, accumulator memories, divider and result register.
`default_nettype none
module ads_dp
	import ads_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic [DimW-1:0] cfg_idx,
	input  wire logic [DimW-1:0] cfg_data,
	input  wire ads_cmd_t        cmd,
	input  wire logic            idle,
	output ads_sts_t             sts,
	ads_pix_if.sink              src,
	ads_res_if.source            dst
);
	logic [DimW-1:0] sw_q, sh_q, dw_q, dh_q;
	logic            fc_q;
	logic [DimW-1:0] wd, hd, wn, hn;
	logic [2*DimW-1:0] area_q;

	logic [DimW-1:0]  sx_q, sy_q;
	logic [AddrW-1:0] tc_q, ty_q, clr_q;
	logic [PosW-1:0]  xs_q, xb_q, ys_q, yb_q;
	logic             bank_q;
	logic [PosW-1:0]  xe, ye;
	logic             cd, rd;

	logic [DimW-1:0]  wxc_q, wxn_q, wyc_q, wyn_q;
	logic             cd_q, rd_q, re_q, fe_q;
	logic [Lanes-1:0][7:0]       v_q;
	logic [Lanes-1:0][PartW-1:0] cpc_q, cpn_q;
	logic [Lanes-1:0][SumW-1:0]  pc_q, pn_q;

	logic [Lanes-1:0][SumW-1:0] m0 [0:MaxWidth-1];
	logic [Lanes-1:0][SumW-1:0] m1 [0:MaxWidth-1];
	logic [Lanes-1:0][SumW-1:0] r0_q, r1_q, cur_rd, nxt_rd, cur_wr, nxt_wr, sum_c;
	logic [AddrW-1:0] waddr;
	logic             we;

	logic [Lanes-1:0][SumW+1:0] rem_q;
	logic [Lanes-1:0][QuoW-1:0] quo_q;
	logic [SumW-3:0]            dsh_q;
	logic [3:0]                 step_q;
	logic                       ov_q;
	logic [Lanes-1:0][7:0]      o_q;
	logic                       ore_q, ofe_q;

	assign sts.cfg_hit  = cfg_we && cfg_idx <= {{(DimW-3){1'b0}}, RegFourChan};
	assign sts.clr_last = clr_q == {AddrW{1'b1}};
	assign sts.take     = src.valid && src.ready;
	assign sts.col_done = cd_q;
	assign sts.row_done = rd_q;
	assign sts.div_last = step_q == 4'd0;
	assign sts.out_full = ov_q && !dst.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q <= DimW'(1);
			sh_q <= DimW'(1);
			dw_q <= DimW'(1);
			dh_q <= DimW'(1);
			fc_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				{{(DimW-3){1'b0}}, RegSrcWidth}:  sw_q <= cfg_data;
				{{(DimW-3){1'b0}}, RegSrcHeight}: sh_q <= cfg_data;
				{{(DimW-3){1'b0}}, RegDstWidth}:  dw_q <= cfg_data;
				{{(DimW-3){1'b0}}, RegDstHeight}: dh_q <= cfg_data;
				{{(DimW-3){1'b0}}, RegFourChan}:  fc_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		wd = (sw_q == '0) ? DimW'(1) : ((sw_q > DimW'(MaxWidth)) ? DimW'(MaxWidth) : sw_q);
		hd = (sh_q == '0) ? DimW'(1) : ((sh_q > DimW'(MaxHeight)) ? DimW'(MaxHeight) : sh_q);
		wn = (dw_q == '0) ? DimW'(1) : ((dw_q > wd) ? wd : dw_q);
		hn = (dh_q == '0) ? DimW'(1) : ((dh_q > hd) ? hd : dh_q);
		xe = xs_q + PosW'(wn);
		ye = ys_q + PosW'(hn);
		cd = xe >= xb_q;
		rd = ye >= yb_q;
	end

	always_ff @(posedge clk) area_q <= wd * hd;

	assign src.ready = idle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			sx_q <= '0; sy_q <= '0; tc_q <= '0; ty_q <= '0;
			xs_q <= '0; ys_q <= '0; xb_q <= PosW'(1); yb_q <= PosW'(1);
			bank_q <= 1'b0;
		end else if (sts.cfg_hit) begin
			clr_q <= '0;
		end else if (cmd.clr) begin
			clr_q <= clr_q + 1'b1;
			sx_q <= '0; sy_q <= '0; tc_q <= '0; ty_q <= '0;
			xs_q <= '0; ys_q <= '0; xb_q <= PosW'(wd); yb_q <= PosW'(hd);
			bank_q <= 1'b0;
		end else if (cmd.adv) begin
			if (sx_q + 1'b1 >= wd) begin
				sx_q <= '0; tc_q <= '0; xs_q <= '0; xb_q <= PosW'(wd);
				if (sy_q + 1'b1 >= hd) begin
					sy_q <= '0; ty_q <= '0; ys_q <= '0; yb_q <= PosW'(hd);
					bank_q <= 1'b0;
				end else begin
					sy_q <= sy_q + 1'b1;
					ys_q <= ys_q + PosW'(hn);
					if (rd_q) begin
						ty_q <= ty_q + 1'b1;
						yb_q <= yb_q + PosW'(hd);
						bank_q <= ~bank_q;
					end
				end
			end else begin
				sx_q <= sx_q + 1'b1;
				xs_q <= xs_q + PosW'(wn);
				if (cd_q) begin
					tc_q <= tc_q + 1'b1;
					xb_q <= xb_q + PosW'(wd);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && src.valid) begin
			v_q[0] <= src.chan_a_in;
			v_q[1] <= fc_q ? src.chan_b_in : 8'd0;
			v_q[2] <= fc_q ? src.chan_c_in : 8'd0;
			v_q[3] <= fc_q ? src.chan_d_in : 8'd0;
			cd_q  <= cd;
			rd_q  <= rd;
			wxc_q <= DimW'((cd ? xb_q : xe) - xs_q);
			wxn_q <= cd ? DimW'(xe - xb_q) : '0;
			wyc_q <= DimW'((rd ? yb_q : ye) - ys_q);
			wyn_q <= rd ? DimW'(ye - yb_q) : '0;
			re_q  <= tc_q == AddrW'(wn - 1'b1);
			fe_q  <= (tc_q == AddrW'(wn - 1'b1)) && (ty_q == AddrW'(hn - 1'b1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpc_q <= '0;
			cpn_q <= '0;
		end else if (cmd.clr || (cmd.adv && sx_q + 1'b1 >= wd)) begin
			cpc_q <= '0;
			cpn_q <= '0;
		end else if (cmd.mul1) begin
			for (int i = 0; i < Lanes; i++) begin
				cpc_q[i] <= cpc_q[i] + PartW'(wxc_q) * PartW'(v_q[i]);
				cpn_q[i] <= cpn_q[i] + PartW'(wxn_q) * PartW'(v_q[i]);
			end
		end else if (cmd.mul2) begin
			cpc_q <= cpn_q;
			cpn_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul2) begin
			for (int i = 0; i < Lanes; i++) begin
				pc_q[i] <= SumW'(wyc_q) * SumW'(cpc_q[i]);
				pn_q[i] <= SumW'(wyn_q) * SumW'(cpc_q[i]);
			end
		end
	end

	always_comb begin
		cur_rd = bank_q ? r1_q : r0_q;
		nxt_rd = bank_q ? r0_q : r1_q;
		for (int i = 0; i < Lanes; i++) begin
			sum_c[i]  = cur_rd[i] + pc_q[i];
			nxt_wr[i] = nxt_rd[i] + pn_q[i];
		end
		cur_wr = rd_q ? '0 : sum_c;
		we     = cmd.clr || cmd.wb;
		waddr  = cmd.clr ? clr_q : tc_q;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			m0[waddr] <= cmd.clr ? '0 : (bank_q ? nxt_wr : cur_wr);
			m1[waddr] <= cmd.clr ? '0 : (bank_q ? cur_wr : nxt_wr);
		end
		r0_q <= m0[tc_q];
		r1_q <= m1[tc_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.wb) begin
			for (int i = 0; i < Lanes; i++) begin
				rem_q[i] <= {sum_c[i], 1'b0} + (SumW+2)'(area_q);
				quo_q[i] <= '0;
			end
			dsh_q  <= {area_q[2*DimW-2:0], 1'b0, 8'd0};
			step_q <= 4'(DivSteps - 1);
		end else if (cmd.div) begin
			for (int i = 0; i < Lanes; i++) begin
				if (rem_q[i] >= (SumW+2)'(dsh_q)) begin
					rem_q[i] <= rem_q[i] - (SumW+2)'(dsh_q);
					quo_q[i] <= {quo_q[i][QuoW-2:0], 1'b1};
				end else begin
					quo_q[i] <= {quo_q[i][QuoW-2:0], 1'b0};
				end
			end
			dsh_q  <= dsh_q >> 1;
			step_q <= step_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.emit) begin
			ov_q <= 1'b1;
		end else if (dst.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			for (int i = 0; i < Lanes; i++)
				o_q[i] <= quo_q[i][QuoW-1] ? 8'hFF : quo_q[i][7:0];
			ore_q <= re_q;
			ofe_q <= fe_q;
		end
	end

	assign dst.valid      = ov_q;
	assign dst.chan_a_out = o_q[0];
	assign dst.chan_b_out = o_q[1];
	assign dst.chan_c_out = o_q[2];
	assign dst.chan_d_out = o_q[3];
	assign dst.row_end    = ore_q;
	assign dst.frame_end  = ofe_q;
endmodule
`default_nettype wire

### rtl/area_downsample_scaler_core.sv
// Top level of the area downsample scaler.
// Source pixels enter in raster order on src, destination pixels leave in raster order
// on dst, each the area-weighted mean of the source pixels it covers, rounded half up.
// A source pixel is loaded and takes the first multiplier step; one that closes a destination
// column also takes the second multiplier step and the accumulator memory write-back, and
// one that completes a destination pixel also takes the 9-step divider and the output step.
// After reset and after every write to registers 0 to 4, a clearing pass over the
// column accumulator memories runs before the first pixel is taken.
`default_nettype none
module area_downsample_scaler_core
	import ads_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic [DimW-1:0] cfg_idx,
	input  wire logic [DimW-1:0] cfg_data,
	ads_pix_if.sink              src,
	ads_res_if.source            dst
);
	ads_cmd_t cmd;
	ads_sts_t sts;
	logic     idle;

	ads_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd),
		.idle   (idle)
	);

	ads_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.idle     (idle),
		.sts      (sts),
		.src      (src),
		.dst      (dst)
	);
endmodule
`default_nettype wire

### test/ads_scale_checker.sv
// Checker that predicts destination pixels of the area downsample scaler and compares them.
`timescale 1ns / 100ps
module ads_scale_checker
	import ads_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic [DimW-1:0] cfg_idx,
	input  wire logic [DimW-1:0] cfg_data,
	ads_pix_if                   pix,
	ads_res_if                   res,
	output int                   errors,
	output int                   pending
);
	typedef struct packed {
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] c;
		logic [7:0] d;
		logic       row_end;
		logic       frame_end;
	} scaled_pix_t;

	scaled_pix_t scaled_q[$];

	longint unsigned sum_cur[MaxWidth*Lanes];
	longint unsigned sum_nxt[MaxWidth*Lanes];
	int unsigned     part_cur[Lanes];
	int unsigned     part_nxt[Lanes];
	int unsigned     scol, srow, tcol, trow;
	int unsigned     reg_sw, reg_sh, reg_dw, reg_dh;
	bit              reg_four;

	function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	task automatic clear_frame(int unsigned entries);
		for (int unsigned i = 0; i < entries; i++) begin
			sum_cur[i] = 0;
			sum_nxt[i] = 0;
		end
		for (int i = 0; i < Lanes; i++) begin
			part_cur[i] = 0;
			part_nxt[i] = 0;
		end
		scol = 0;
		srow = 0;
		tcol = 0;
		trow = 0;
	endtask

	task automatic report(string what, int got, int want);
		$display("%0t: %s got %0d want %0d", $realtime, what, got, want);
		errors++;
	endtask

	task automatic scale_pixel(logic [7:0] ca, logic [7:0] cb, logic [7:0] cc, logic [7:0] cd);
		int unsigned     sw, sh, dw, dh, nch, xe, xb, wxc, wxn, ye, yb, wyc, wyn, base;
		int unsigned     v[Lanes];
		int unsigned     q[Lanes];
		longint unsigned area;
		bit              col_done, row_done;
		scaled_pix_t     sp;
		sw = clamp_dim(reg_sw, MaxWidth);
		sh = clamp_dim(reg_sh, MaxHeight);
		dw = clamp_dim(reg_dw, sw);
		dh = clamp_dim(reg_dh, sh);
		nch = reg_four ? Lanes : 1;
		v[0] = ca;
		v[1] = reg_four ? cb : 0;
		v[2] = reg_four ? cc : 0;
		v[3] = reg_four ? cd : 0;
		xe = (scol + 1) * dw;
		xb = (tcol + 1) * sw;
		col_done = xe >= xb;
		wxc = (col_done ? xb : xe) - scol * dw;
		wxn = col_done ? xe - xb : 0;
		ye = (srow + 1) * dh;
		yb = (trow + 1) * sh;
		row_done = ye >= yb;
		wyc = (row_done ? yb : ye) - srow * dh;
		wyn = row_done ? ye - yb : 0;
		for (int i = 0; i < nch; i++) begin
			part_cur[i] += wxc * v[i];
			part_nxt[i] += wxn * v[i];
		end
		if (col_done) begin
			base = tcol * Lanes;
			area = longint'(sw) * longint'(sh);
			for (int i = 0; i < nch; i++) begin
				sum_cur[base+i] += longint'(wyc) * longint'(part_cur[i]);
				sum_nxt[base+i] += longint'(wyn) * longint'(part_cur[i]);
				part_cur[i] = part_nxt[i];
				part_nxt[i] = 0;
			end
			if (row_done) begin
				for (int i = 0; i < Lanes; i++) begin
					q[i] = 0;
					if (i < nch) begin
						q[i] = int'((2 * sum_cur[base+i] + area) / (2 * area));
						if (q[i] > 255) q[i] = 255;
						sum_cur[base+i] = 0;
					end
				end
				sp.a = 8'(q[0]);
				sp.b = 8'(q[1]);
				sp.c = 8'(q[2]);
				sp.d = 8'(q[3]);
				sp.row_end = (tcol == dw - 1);
				sp.frame_end = sp.row_end && (trow == dh - 1);
				scaled_q.push_back(sp);
			end
			tcol++;
		end
		if (scol + 1 >= sw) begin
			scol = 0;
			tcol = 0;
			for (int i = 0; i < Lanes; i++) begin
				part_cur[i] = 0;
				part_nxt[i] = 0;
			end
			if (row_done) begin
				for (int unsigned i = 0; i < dw * Lanes; i++) begin
					sum_cur[i] = sum_nxt[i];
					sum_nxt[i] = 0;
				end
				trow++;
			end
			srow++;
			if (srow >= sh) clear_frame(dw * Lanes);
		end else begin
			scol++;
		end
	endtask

	task automatic check_pixel();
		scaled_pix_t want;
		if (scaled_q.size() == 0) begin
			$display("%0t: destination pixel with none predicted", $realtime);
			errors++;
			return;
		end
		want = scaled_q.pop_front();
		if (res.chan_a_out !== want.a) report("chan_a_out", res.chan_a_out, want.a);
		if (res.chan_b_out !== want.b) report("chan_b_out", res.chan_b_out, want.b);
		if (res.chan_c_out !== want.c) report("chan_c_out", res.chan_c_out, want.c);
		if (res.chan_d_out !== want.d) report("chan_d_out", res.chan_d_out, want.d);
		if (res.row_end !== want.row_end) report("row_end", res.row_end, want.row_end);
		if (res.frame_end !== want.frame_end) report("frame_end", res.frame_end, want.frame_end);
	endtask

	initial begin
		errors = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_sw = 1;
			reg_sh = 1;
			reg_dw = 1;
			reg_dh = 1;
			reg_four = 0;
			clear_frame(MaxWidth * Lanes);
			scaled_q.delete();
		end else begin
			if (cfg_we && cfg_idx <= RegFourChan) begin
				case (cfg_idx[2:0])
					RegSrcWidth: reg_sw = cfg_data;
					RegSrcHeight: reg_sh = cfg_data;
					RegDstWidth: reg_dw = cfg_data;
					RegDstHeight: reg_dh = cfg_data;
					default: reg_four = cfg_data[0];
				endcase
				clear_frame(MaxWidth * Lanes);
			end
			if (pix.valid && pix.ready)
				scale_pixel(pix.chan_a_in, pix.chan_b_in, pix.chan_c_in, pix.chan_d_in);
			if (res.valid && res.ready) check_pixel();
		end
		pending = scaled_q.size();
	end
endmodule

### test/tb_area_downsample_scaler_core.sv
// Testbench top: drives source pixels and register writes, and gives the verdict.
`timescale 1ns / 100ps
module tb_area_downsample_scaler_core;
	import ads_pkg::*;

	localparam int IdleLimit = 60000;

	logic            clk = 0;
	logic            arst_n = 0;
	logic            cfg_we = 0;
	logic [DimW-1:0] cfg_idx = 0;
	logic [DimW-1:0] cfg_data = 0;
	int              errors, pending;
	int              idle_cycles = 0;
	int              rand_items = 0;
	bit              burst = 0;

	ads_pix_if src_ch();
	ads_res_if dst_ch();

	initial begin
		src_ch.valid = 0;
		src_ch.chan_a_in = 0;
		src_ch.chan_b_in = 0;
		src_ch.chan_c_in = 0;
		src_ch.chan_d_in = 0;
		dst_ch.ready = 0;
	end

	area_downsample_scaler_core u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.src(src_ch), .dst(dst_ch)
	);

	ads_scale_checker u_chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.pix(src_ch), .res(dst_ch), .errors(errors), .pending(pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if ((src_ch.valid && src_ch.ready) || (dst_ch.valid && dst_ch.ready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = burst ? 0 : $urandom_range(0, 16);
			repeat (n) begin
				@(negedge clk);
				dst_ch.ready <= 0;
			end
			@(negedge clk);
			dst_ch.ready <= 1;
			do @(posedge clk); while (!dst_ch.valid);
		end
	end

	task automatic send_pixel(logic [7:0] a, logic [7:0] b, logic [7:0] c, logic [7:0] d);
		int n;
		n = burst ? 0 : $urandom_range(0, 16);
		repeat (n) begin
			@(negedge clk);
			src_ch.valid <= 0;
		end
		@(negedge clk);
		src_ch.valid <= 1;
		src_ch.chan_a_in <= a;
		src_ch.chan_b_in <= b;
		src_ch.chan_c_in <= c;
		src_ch.chan_d_in <= d;
		do @(posedge clk); while (!src_ch.ready);
	endtask

	function automatic logic [7:0] pick_level();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_random(int count);
		repeat (count) begin
			send_pixel(pick_level(), pick_level(), pick_level(), pick_level());
			rand_items++;
		end
	endtask

	task automatic write_reg(logic [DimW-1:0] idx, logic [DimW-1:0] data);
		@(negedge clk);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_data <= data;
	endtask

	task automatic set_sizes(int sw, int sh, int dw, int dh, bit four);
		@(negedge clk);
		src_ch.valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (40) @(negedge clk);
		write_reg(DimW'(RegSrcWidth), DimW'(sw));
		write_reg(DimW'(RegSrcHeight), DimW'(sh));
		write_reg(DimW'(RegDstWidth), DimW'(dw));
		write_reg(DimW'(RegDstHeight), DimW'(dh));
		write_reg(DimW'(RegFourChan), DimW'(four));
		@(negedge clk);
		cfg_we <= 0;
	endtask

	initial begin
		int sw, sh, frames, count;
		repeat (11) @(negedge clk);
		arst_n = 1;

		send_pixel(8'h00, 8'hFF, 8'hFF, 8'hFF);
		send_pixel(8'hFF, 8'h00, 8'h00, 8'h00);
		send_pixel(8'hAA, 8'h55, 8'h55, 8'h55);

		set_sizes(0, 0, 0, 0, 1);
		send_pixel(8'hFF, 8'h00, 8'hAA, 8'h55);
		send_pixel(8'h00, 8'hFF, 8'h55, 8'hAA);

		set_sizes(2, 2, 1, 1, 1);
		repeat (4) send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);

		set_sizes(3, 3, 2, 2, 1);
		repeat (9) send_pixel(pick_level(), pick_level(), pick_level(), pick_level());

		@(negedge clk);
		src_ch.valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (40) @(negedge clk);
		write_reg(DimW'(7), 13'h1FFF);
		@(negedge clk);
		cfg_we <= 0;
		send_pixel(8'h01, 8'h02, 8'h03, 8'h04);
		send_pixel(8'hFE, 8'hFD, 8'hFC, 8'hFB);

		set_sizes(8191, 1, 8191, 1, $urandom_range(0, 1));
		send_random(100);
		set_sizes(1, 8191, 1, 8191, $urandom_range(0, 1));
		send_random(100);
		set_sizes(4096, 4096, 1, 1, 1);
		send_random(50);
		set_sizes(4096, 4096, 4096, 4096, 0);
		send_random(50);

		rand_items = 0;
		while (rand_items < 560) begin
			sw = $urandom_range(1, 12);
			sh = $urandom_range(1, 12);
			burst = ($urandom_range(0, 3) == 0);
			set_sizes(sw, sh, $urandom_range(0, sw + 2), $urandom_range(0, sh + 2),
				$urandom_range(0, 1));
			frames = $urandom_range(1, 3);
			count = frames * sw * sh;
			if ($urandom_range(0, 4) == 0 && sw * sh > 1) count = $urandom_range(1, sw * sh - 1);
			send_random(count);
		end

		@(negedge clk);
		src_ch.valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
